[src/lpg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpg_pkg
// Widths, types, codes and helpers shared by the line pixel generator.
// ----------------------------------------------------------------------------
package lpg_pkg;

    localparam int COORD_WIDTH   = 16;
    localparam int SPAN_WIDTH    = COORD_WIDTH + 1;
    localparam int ERR_WIDTH     = COORD_WIDTH + 3;
    localparam int E2_WIDTH      = ERR_WIDTH + 1;
    localparam int DIM_WIDTH     = 13;
    localparam int PIX_WIDTH     = 12;
    localparam int INDEX_WIDTH   = 24;
    localparam int COLOUR_WIDTH  = 32;
    localparam int PROD_WIDTH    = PIX_WIDTH + DIM_WIDTH;
    localparam int CMP_WIDTH     = ((COORD_WIDTH > DIM_WIDTH) ? COORD_WIDTH : DIM_WIDTH) + 1;
    localparam int CFG_IDX_WIDTH = 1;

    localparam logic [DIM_WIDTH-1:0] SCREEN_MAX   = DIM_WIDTH'(4096);
    localparam logic [DIM_WIDTH-1:0] WIDTH_RESET  = DIM_WIDTH'(640);
    localparam logic [DIM_WIDTH-1:0] HEIGHT_RESET = DIM_WIDTH'(480);

    // Input word kinds
    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_ADVANCE = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_SCREEN_WIDTH  = CFG_IDX_WIDTH'(0);
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_SCREEN_HEIGHT = CFG_IDX_WIDTH'(1);

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [SPAN_WIDTH-1:0]  t_span;
    typedef logic signed [ERR_WIDTH-1:0]   t_err;
    typedef logic signed [E2_WIDTH-1:0]    t_e2;
    typedef logic signed [CMP_WIDTH-1:0]   t_cmp;
    typedef logic [DIM_WIDTH-1:0]          t_dim;
    typedef logic [PIX_WIDTH-1:0]          t_pix;

    // Zero counts as 1, anything above the screen maximum as the maximum
    function automatic t_dim eff_bound(input t_dim b);
        t_dim r;
        if (b == '0) begin
            r = DIM_WIDTH'(1);
        end else if (b > SCREEN_MAX) begin
            r = SCREEN_MAX;
        end else begin
            r = b;
        end
        return r;
    endfunction

    function automatic t_pix clamp_coord(input t_coord v, input t_dim bound);
        t_cmp v_c;
        t_cmp b_c;
        t_pix r;
        v_c = CMP_WIDTH'(v);
        b_c = CMP_WIDTH'($signed({1'b0, bound}));
        if (v_c < 0) begin
            r = '0;
        end else if (v_c >= b_c) begin
            r = PIX_WIDTH'(bound - 1'b1);
        end else begin
            r = PIX_WIDTH'(v_c);
        end
        return r;
    endfunction

endpackage

[src/line_pixel_generator_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_pixel_generator_unit
// Bresenham line engine: load a line, then emit one clamped pixel per advance while a line is active.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+---------------------------
//  in       | input     | i_in_valid / o_in_ready  | kind, end points, colour
//  out      | output    | o_out_valid / i_out_ready| pixel x, y, index, colour, last
//  cfg      | input     | i_cfg_valid / o_cfg_ready| register index, data
//
//  One word per clock while o_in_ready is high. Line state updates in the
//  accept cycle; a pixel passes a clamp register and then a multiply-add
//  register before it appears. Reset (synchronous) leaves the engine idle,
//  width 640, height 480. A stalled output holds the pipe; input is still
//  taken while the clamp stage has room.
module line_pixel_generator_unit
    import lpg_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,

    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_WIDTH-1:0] i_cfg_index,
    input  logic [DIM_WIDTH-1:0]     i_cfg_data,

    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_kind,
    input  logic signed [COORD_WIDTH-1:0] i_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_end_y,
    input  logic [COLOUR_WIDTH-1:0]  i_line_colour,

    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [PIX_WIDTH-1:0]     o_pixel_x,
    output logic [PIX_WIDTH-1:0]     o_pixel_y,
    output logic [INDEX_WIDTH-1:0]   o_pixel_index,
    output logic [COLOUR_WIDTH-1:0]  o_pixel_colour,
    output logic                     o_last_pixel
);

    // configuration, held as effective bounds
    t_dim r_eff_w;
    t_dim r_eff_h;

    // line state
    logic   r_active;
    t_coord r_cur_x, r_cur_y, r_stop_x, r_stop_y;
    t_span  r_span_x, r_span_y_neg;
    logic   r_dir_x_neg, r_dir_y_neg;
    t_err   r_err;
    logic [COLOUR_WIDTH-1:0] r_colour;

    t_coord n_cur_x, n_cur_y;
    t_err   n_err;

    // clamp stage
    logic   r_s1_valid;
    t_pix   r_s1_px, r_s1_py;
    logic   r_s1_last;
    logic [COLOUR_WIDTH-1:0] r_s1_colour;

    // output stage
    logic   r_out_valid;

    logic   w_s2_free, w_in_acc, w_load, w_adv;
    t_e2    w_e2;
    logic   w_go_x, w_go_y, w_x_end, w_y_end, w_last;
    t_span  w_dx, w_dy;
    logic [PROD_WIDTH-1:0] w_prod, w_sum;

    assign o_cfg_ready = 1'b1;

    assign w_s2_free  = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || w_s2_free;
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_load     = w_in_acc && (i_kind == KIND_LOAD);
    assign w_adv      = w_in_acc && (i_kind == KIND_ADVANCE) && r_active;

    // one error step
    assign w_e2    = {r_err, 1'b0};
    assign w_go_x  = w_e2 >= E2_WIDTH'(r_span_y_neg);
    assign w_x_end = w_go_x && (r_cur_x == r_stop_x);
    assign w_go_y  = !w_x_end && (w_e2 <= E2_WIDTH'(r_span_x));
    assign w_y_end = w_go_y && (r_cur_y == r_stop_y);
    assign w_last  = w_x_end || w_y_end;

    always_comb begin
        n_err   = r_err;
        n_cur_x = r_cur_x;
        n_cur_y = r_cur_y;
        if (w_go_x && !w_x_end) begin
            n_err   = n_err + ERR_WIDTH'(r_span_y_neg);
            n_cur_x = r_dir_x_neg ? r_cur_x - 1'b1 : r_cur_x + 1'b1;
        end
        if (w_go_y && !w_y_end) begin
            n_err   = n_err + ERR_WIDTH'(r_span_x);
            n_cur_y = r_dir_y_neg ? r_cur_y - 1'b1 : r_cur_y + 1'b1;
        end
    end

    assign w_dx = SPAN_WIDTH'(i_start_x) - SPAN_WIDTH'(i_end_x);
    assign w_dy = SPAN_WIDTH'(i_start_y) - SPAN_WIDTH'(i_end_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_w <= WIDTH_RESET;
            r_eff_h <= HEIGHT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SCREEN_WIDTH:  r_eff_w <= eff_bound(i_cfg_data);
                CFG_SCREEN_HEIGHT: r_eff_h <= eff_bound(i_cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (w_load) begin
            r_active <= 1'b1;
        end else if (w_adv && w_last) begin
            r_active <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_cur_x      <= i_start_x;
            r_cur_y      <= i_start_y;
            r_stop_x     <= i_end_x;
            r_stop_y     <= i_end_y;
            r_span_x     <= (w_dx < 0) ? -w_dx : w_dx;
            r_span_y_neg <= (w_dy < 0) ? w_dy : -w_dy;
            r_dir_x_neg  <= !(i_start_x < i_end_x);
            r_dir_y_neg  <= !(i_start_y < i_end_y);
            r_err        <= ERR_WIDTH'((w_dx < 0) ? -w_dx : w_dx)
                          + ERR_WIDTH'((w_dy < 0) ? w_dy : -w_dy);
            r_colour     <= i_line_colour;
        end else if (w_adv) begin
            r_cur_x <= n_cur_x;
            r_cur_y <= n_cur_y;
            r_err   <= n_err;
        end
    end

    // clamp stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= w_adv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_px     <= clamp_coord(r_cur_x, r_eff_w);
            r_s1_py     <= clamp_coord(r_cur_y, r_eff_h);
            r_s1_last   <= w_last;
            r_s1_colour <= r_colour;
        end
    end

    // row index: y times stride plus x
    assign w_prod = PROD_WIDTH'(r_s1_py) * PROD_WIDTH'(r_eff_w);
    assign w_sum  = w_prod + PROD_WIDTH'(r_s1_px);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s2_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_free && r_s1_valid) begin
            o_pixel_x      <= r_s1_px;
            o_pixel_y      <= r_s1_py;
            o_pixel_index  <= w_sum[INDEX_WIDTH-1:0];
            o_pixel_colour <= r_s1_colour;
            o_last_pixel   <= r_s1_last;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTH
    a_idle_adv_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_kind == KIND_ADVANCE) && !r_active) |=> !r_s1_valid)
        else $error("advance while idle produced a pixel");

    a_adv_makes_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_s1_valid)
        else $error("active advance lost its pixel");

    a_last_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_last && !w_load) |=> !r_active)
        else $error("engine still active after last pixel");

    a_x_in_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (DIM_WIDTH'(o_pixel_x) < r_eff_w && DIM_WIDTH'(o_pixel_y) < r_eff_h))
        else $error("pixel outside the screen");

    a_index_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (PROD_WIDTH'(o_pixel_index) ==
                         PROD_WIDTH'(o_pixel_y) * PROD_WIDTH'(r_eff_w)
                         + PROD_WIDTH'(o_pixel_x)))
        else $error("pixel index does not match coordinates");
`endif

endmodule
